/* design/hfb_pkg.sv */
// Shared types and constants for the RGB565 horizontal fade blend unit.
`default_nettype none
package hfb_pkg;

  localparam int PIX_W   = 16;
  localparam int FADE_W  = 12;
  localparam int OFF_W   = 12;
  localparam int ALPHA_W = 8;
  localparam int NUM_W   = 20;
  localparam int CFG_IDX_W = 1;

  localparam logic [ALPHA_W-1:0] ALPHA_FULL = 8'd255;
  localparam logic [7:0]         ROUND_HALF = 8'd128;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STRIP_LEN  = 1'b0,
    CFG_BACKGROUND = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [PIX_W-1:0]   pixel;
    logic [NUM_W-1:0]   rem;
    logic [ALPHA_W-1:0] quo;
    logic               bypass;
  } div_item_t;

  typedef struct packed {
    logic [PIX_W-1:0]   pixel;
    logic [ALPHA_W-1:0] alpha;
    logic               bypass;
  } alpha_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             bypass;
    logic [12:0]      r_src;
    logic [12:0]      r_bg;
    logic [13:0]      g_src;
    logic [13:0]      g_bg;
    logic [12:0]      b_src;
    logic [12:0]      b_bg;
  } prod_item_t;

endpackage
`default_nettype wire

/* design/hfb_if.sv */
// Stream interfaces for the pixel input and blended pixel output channels.
`default_nettype none
interface hfb_in_if;
  logic                           valid;
  logic                           ready;
  logic [hfb_pkg::PIX_W-1:0]      pixel_in;
  logic [hfb_pkg::OFF_W-1:0]      column_offset;

  modport source (output valid, output pixel_in, output column_offset, input ready);
  modport sink (input valid, input pixel_in, input column_offset, output ready);
endinterface

interface hfb_out_if;
  logic                      valid;
  logic                      ready;
  logic [hfb_pkg::PIX_W-1:0] pixel_out;

  modport source (output valid, output pixel_out, input ready);
  modport sink (input valid, input pixel_out, output ready);
endinterface
`default_nettype wire

/* design/hfb_alpha_div.sv */
// Pipelined alpha computation: (offset+1)*255 / strip length, one quotient bit per divider stage.
`default_nettype none
module hfb_alpha_div (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [hfb_pkg::FADE_W-1:0]   strip_len,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [hfb_pkg::PIX_W-1:0]    in_pixel,
  input  wire logic [hfb_pkg::OFF_W-1:0]    in_offset,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output hfb_pkg::alpha_item_t              out_item
);

  localparam int STAGES = hfb_pkg::ALPHA_W + 2;

  logic [STAGES-1:0]  v;
  logic [STAGES:0]    rdy;
  hfb_pkg::div_item_t d      [STAGES];
  hfb_pkg::div_item_t d_next [STAGES];

  logic [hfb_pkg::OFF_W:0]   off1;
  logic [hfb_pkg::OFF_W+8:0] num_full;
  logic [hfb_pkg::NUM_W-1:0] fw_sat;

  assign rdy[STAGES] = out_ready;
  assign in_ready    = rdy[0];

  genvar i;
  generate
    for (i = 0; i < STAGES; i++) begin : g_rdy
      assign rdy[i] = !v[i] || rdy[i+1];
    end
  endgenerate

  // stage 0: numerator = (off+1)*255 = (off+1)*256 - (off+1)
  assign off1     = {1'b0, in_offset} + {{hfb_pkg::OFF_W{1'b0}}, 1'b1};
  assign num_full = {off1, 8'h00} - {8'h00, off1};

  always_comb begin
    d_next[0].pixel  = in_pixel;
    d_next[0].rem    = num_full[hfb_pkg::NUM_W-1:0];
    d_next[0].quo    = '0;
    d_next[0].bypass = 1'b0;
  end

  // stage 1: zero width or quotient >= 256 both leave the pixel unchanged
  assign fw_sat = {strip_len, 8'h00};

  always_comb begin
    d_next[1]        = d[0];
    d_next[1].bypass = (strip_len == '0) || (d[0].rem >= fw_sat);
  end

  generate
    for (i = 2; i < STAGES; i++) begin : g_bit
      localparam int K = STAGES - 1 - i;
      logic [hfb_pkg::NUM_W-1:0] dsor;
      assign dsor = {{(hfb_pkg::NUM_W-hfb_pkg::FADE_W){1'b0}}, strip_len} << K;
      always_comb begin
        d_next[i] = d[i-1];
        if (d[i-1].rem >= dsor) begin
          d_next[i].rem    = d[i-1].rem - dsor;
          d_next[i].quo[K] = 1'b1;
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (rdy[0]) begin
      v[0] <= in_valid;
    end
    if (rdy[0] && in_valid) begin
      d[0] <= d_next[0];
    end
  end

  generate
    for (i = 1; i < STAGES; i++) begin : g_stage
      always_ff @(posedge clk) begin
        if (rst) begin
          v[i] <= 1'b0;
        end else if (rdy[i]) begin
          v[i] <= v[i-1];
        end
        if (rdy[i] && v[i-1]) begin
          d[i] <= d_next[i];
        end
      end
    end
  endgenerate

  assign out_valid       = v[STAGES-1];
  assign out_item.pixel  = d[STAGES-1].pixel;
  assign out_item.alpha  = d[STAGES-1].quo;
  assign out_item.bypass = d[STAGES-1].bypass;

endmodule
`default_nettype wire

/* design/hfb_blend.sv */
// Two-stage per-channel blend of the pixel over the background and RGB565 repack.
`default_nettype none
module hfb_blend (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic [hfb_pkg::PIX_W-1:0]  background_color,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire hfb_pkg::alpha_item_t       in_item,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [hfb_pkg::PIX_W-1:0]       out_pixel
);

  logic                      v0;
  logic                      v1;
  logic                      rdy0;
  logic                      rdy1;
  hfb_pkg::prod_item_t       p;
  hfb_pkg::prod_item_t       p_next;
  logic [hfb_pkg::PIX_W-1:0] pix;
  logic [hfb_pkg::PIX_W-1:0] pix_next;

  logic [7:0]  a;
  logic [7:0]  na;
  logic [12:0] sum_r;
  logic [13:0] sum_g;
  logic [12:0] sum_b;

  assign rdy1     = !v1 || out_ready;
  assign rdy0     = !v0 || rdy1;
  assign in_ready = rdy0;

  assign a  = in_item.alpha;
  assign na = hfb_pkg::ALPHA_FULL - in_item.alpha;

  always_comb begin
    p_next.pixel  = in_item.pixel;
    p_next.bypass = in_item.bypass;
    p_next.r_src  = {8'h00, in_item.pixel[15:11]} * {5'h00, a};
    p_next.r_bg   = {8'h00, background_color[15:11]} * {5'h00, na};
    p_next.g_src  = {8'h00, in_item.pixel[10:5]} * {6'h00, a};
    p_next.g_bg   = {8'h00, background_color[10:5]} * {6'h00, na};
    p_next.b_src  = {8'h00, in_item.pixel[4:0]} * {5'h00, a};
    p_next.b_bg   = {8'h00, background_color[4:0]} * {5'h00, na};
  end

  assign sum_r = p.r_src + p.r_bg + {5'h00, hfb_pkg::ROUND_HALF};
  assign sum_g = p.g_src + p.g_bg + {6'h00, hfb_pkg::ROUND_HALF};
  assign sum_b = p.b_src + p.b_bg + {5'h00, hfb_pkg::ROUND_HALF};

  assign pix_next = p.bypass ? p.pixel : {sum_r[12:8], sum_g[13:8], sum_b[12:8]};

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else begin
      if (rdy0) begin
        v0 <= in_valid;
      end
      if (rdy1) begin
        v1 <= v0;
      end
    end
    if (rdy0 && in_valid) begin
      p <= p_next;
    end
    if (rdy1 && v0) begin
      pix <= pix_next;
    end
  end

  assign out_valid = v1;
  assign out_pixel = pix;

endmodule
`default_nettype wire

/* design/rgb565_horizontal_fade_blend_unit.sv */
// Top level of the RGB565 horizontal fade blend unit.
`default_nettype none
// Blends a stream of RGB565 pixels toward a background color with an opacity that ramps
// across a fade strip: alpha = min(255, (column_offset+1)*255 / strip length). One pixel is
// taken per clock while no output stall holds the input. Stage 0 forms the numerator and stage
// 1 the saturation test, an eight-stage restoring divider yields one alpha bit per stage, and
// the blend's product and pixel registers multiply, round and repack.
// A stall on the output fills empty stages first before holding the input. Write the strip
// length and background_color only while no pixel is in flight; a strip length of zero, or an
// offset whose unclamped quotient is 256 or more, passes the pixel through unchanged.
module rgb565_horizontal_fade_blend_unit (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [hfb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [hfb_pkg::PIX_W-1:0]       cfg_data,
  hfb_in_if.sink                               pixel_stream,
  hfb_out_if.source                            result_stream
);

  logic [hfb_pkg::FADE_W-1:0] strip_len;
  logic [hfb_pkg::PIX_W-1:0]  background_color;

  logic                 mid_valid;
  logic                 mid_ready;
  hfb_pkg::alpha_item_t mid_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      strip_len        <= '0;
      background_color <= '0;
    end else if (cfg_we) begin
      unique case (hfb_pkg::cfg_index_t'(cfg_index))
        hfb_pkg::CFG_STRIP_LEN:  strip_len        <= cfg_data[hfb_pkg::FADE_W-1:0];
        hfb_pkg::CFG_BACKGROUND: background_color <= cfg_data;
        default: ;
      endcase
    end
  end

  hfb_alpha_div u_alpha_div (
    .clk        (clk),
    .rst        (rst),
    .strip_len  (strip_len),
    .in_valid   (pixel_stream.valid),
    .in_ready   (pixel_stream.ready),
    .in_pixel   (pixel_stream.pixel_in),
    .in_offset  (pixel_stream.column_offset),
    .out_valid  (mid_valid),
    .out_ready  (mid_ready),
    .out_item   (mid_item)
  );

  hfb_blend u_blend (
    .clk              (clk),
    .rst              (rst),
    .background_color (background_color),
    .in_valid         (mid_valid),
    .in_ready         (mid_ready),
    .in_item          (mid_item),
    .out_valid        (result_stream.valid),
    .out_ready        (result_stream.ready),
    .out_pixel        (result_stream.pixel_out)
  );

`ifndef SYNTH
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_stream.valid)
    else $error("result valid after reset");

  a_ready_chain: assert property (@(posedge clk) disable iff (rst)
    result_stream.ready |-> pixel_stream.ready)
    else $error("input held while output accepts");

  a_mid_hold: assert property (@(posedge clk) disable iff (rst)
    (mid_valid && !mid_ready) |=> (mid_valid && $stable(mid_item)))
    else $error("stalled alpha transaction lost");
`endif

endmodule
`default_nettype wire

/* verif/tb_top.sv */
// Self-checking testbench for the RGB565 fade blend unit: directed table, then random traffic.
`timescale 1ns / 1ps
module tb_top;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES    = 16;
  localparam int PHASE_ITEMS    = 100;
  localparam int PHASES_PER_MODE = 6;

  typedef struct packed {
    logic         set_cfg;
    logic [11:0]  fade;
    logic [15:0]  bg;
    logic [15:0]  pixel;
    logic [11:0]  offset;
    logic         known;
    logic [15:0]  result;
  } stim_row_t;

  localparam int NUM_ROWS = 20;
  localparam stim_row_t STIM_TABLE [NUM_ROWS] = '{
    // reset registers: blending off
    '{1'b0, 12'd0,    16'h0000, 16'hFFFF, 12'd0,    1'b1, 16'hFFFF},
    '{1'b0, 12'd0,    16'h0000, 16'h0000, 12'd4095, 1'b1, 16'h0000},
    '{1'b0, 12'd0,    16'h0000, 16'hA5A5, 12'd123,  1'b1, 16'hA5A5},
    // one-pixel strip: always saturated
    '{1'b1, 12'd1,    16'h0000, 16'h1234, 12'd0,    1'b1, 16'h1234},
    '{1'b0, 12'd0,    16'h0000, 16'h5A5A, 12'd4095, 1'b1, 16'h5A5A},
    // widest strip, white background
    '{1'b1, 12'd4095, 16'hFFFF, 16'h0000, 12'd0,    1'b1, 16'hFFFF},
    '{1'b0, 12'd0,    16'h0000, 16'h0000, 12'd4094, 1'b1, 16'h0000},
    '{1'b0, 12'd0,    16'h0000, 16'h0000, 12'd4093, 1'b0, 16'h0000},
    '{1'b0, 12'd0,    16'h0000, 16'h8410, 12'd2047, 1'b0, 16'h0000},
    // widest strip, black background
    '{1'b1, 12'd4095, 16'h0000, 16'hFFFF, 12'd0,    1'b1, 16'h0000},
    '{1'b0, 12'd0,    16'h0000, 16'hFFFF, 12'd4095, 1'b1, 16'hFFFF},
    '{1'b0, 12'd0,    16'h0000, 16'hFFFF, 12'd1000, 1'b0, 16'h0000},
    '{1'b1, 12'd2,    16'hF81F, 16'h07E0, 12'd0,    1'b0, 16'h0000},
    '{1'b0, 12'd0,    16'h0000, 16'h07E0, 12'd1,    1'b1, 16'h07E0},
    '{1'b1, 12'd256,  16'h001F, 16'hF800, 12'd127,  1'b0, 16'h0000},
    '{1'b0, 12'd0,    16'h0000, 16'hFFE0, 12'd254,  1'b0, 16'h0000},
    '{1'b0, 12'd0,    16'h0000, 16'h0001, 12'd255,  1'b1, 16'h0001},
    '{1'b1, 12'd4095, 16'hFFFF, 16'hFFFF, 12'd4095, 1'b1, 16'hFFFF},
    '{1'b1, 12'd3,    16'h7BEF, 16'h8410, 12'd1,    1'b0, 16'h0000},
    '{1'b0, 12'd0,    16'h0000, 16'h1F1F, 12'd2,    1'b1, 16'h1F1F}
  };

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          cfg_we;
  logic [hfb_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [hfb_pkg::PIX_W-1:0]     cfg_data;

  hfb_in_if  pix_if ();
  hfb_out_if res_if ();

  rgb565_horizontal_fade_blend_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .pixel_stream  (pix_if),
    .result_stream (res_if)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  logic [hfb_pkg::FADE_W-1:0] strip_len_q;
  logic [hfb_pkg::PIX_W-1:0]  bg_color_q;
  logic [hfb_pkg::PIX_W-1:0]  expected_pixels [$];
  int                         tx_idle_pct;
  int                         rx_idle_pct;
  int                         stall_cycles;
  bit                         failed;

  function automatic int unsigned blend_channel(int unsigned src, int unsigned bg,
                                                int unsigned alpha);
    return (src * alpha + bg * (255 - alpha) + 128) >> 8;
  endfunction

  function automatic logic [hfb_pkg::PIX_W-1:0] fade_pixel(logic [hfb_pkg::PIX_W-1:0] pix,
                                                           logic [hfb_pkg::OFF_W-1:0] off);
    int unsigned alpha;
    int unsigned r;
    int unsigned g;
    int unsigned b;
    logic [hfb_pkg::PIX_W-1:0] packed_pix;
    if (strip_len_q == '0) return pix;
    alpha = ((int'(off) + 1) * 255) / int'(strip_len_q);
    if (alpha > 255) alpha = 255;
    r = blend_channel(pix[15:11], bg_color_q[15:11], alpha);
    g = blend_channel(pix[10:5],  bg_color_q[10:5],  alpha);
    b = blend_channel(pix[4:0],   bg_color_q[4:0],   alpha);
    packed_pix = {r[4:0], g[5:0], b[4:0]};
    return packed_pix;
  endfunction

  task automatic send_pixel(logic [hfb_pkg::PIX_W-1:0] pix, logic [hfb_pkg::OFF_W-1:0] off,
                            logic known, logic [hfb_pkg::PIX_W-1:0] typed);
    while ($urandom_range(99) < tx_idle_pct) begin
      pix_if.valid <= 1'b0;
      @(posedge clk);
    end
    pix_if.valid         <= 1'b1;
    pix_if.pixel_in      <= pix;
    pix_if.column_offset <= off;
    @(posedge clk);
    while (!pix_if.ready) @(posedge clk);
    expected_pixels.push_back(known ? typed : fade_pixel(pix, off));
  endtask

  task automatic load_config(logic [hfb_pkg::FADE_W-1:0] fade,
                             logic [hfb_pkg::PIX_W-1:0] bg);
    pix_if.valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= hfb_pkg::CFG_STRIP_LEN;
    cfg_data  <= {{(hfb_pkg::PIX_W-hfb_pkg::FADE_W){1'b0}}, fade};
    @(posedge clk);
    cfg_index <= hfb_pkg::CFG_BACKGROUND;
    cfg_data  <= bg;
    @(posedge clk);
    cfg_we <= 1'b0;
    strip_len_q = fade;
    bg_color_q  = bg;
  endtask

  // result checker, receiver stalls and watchdog
  always @(posedge clk) begin
    logic [hfb_pkg::PIX_W-1:0] want;
    if (rst) begin
      res_if.ready <= 1'b0;
      stall_cycles <= 0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= rx_idle_pct);
      if (res_if.valid && res_if.ready) begin
        if (expected_pixels.size() == 0) begin
          $error("pixel_out: unexpected transaction, actual %h", res_if.pixel_out);
          failed = 1'b1;
        end else begin
          want = expected_pixels.pop_front();
          if (res_if.pixel_out !== want) begin
            $error("pixel_out: expected %h, actual %h", want, res_if.pixel_out);
            failed = 1'b1;
          end
        end
      end
      if ((res_if.valid && res_if.ready) || (pix_if.valid && pix_if.ready))
        stall_cycles <= 0;
      else if (stall_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end else
        stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic [hfb_pkg::FADE_W-1:0] fade;
    logic [hfb_pkg::PIX_W-1:0]  bg;
    logic [hfb_pkg::OFF_W-1:0]  off;
    int                         sel;
    failed               = 1'b0;
    strip_len_q          = '0;
    bg_color_q           = '0;
    tx_idle_pct          = 10;
    rx_idle_pct          = 68;
    rst                  = 1'b1;
    cfg_we               = 1'b0;
    cfg_index            = hfb_pkg::CFG_STRIP_LEN;
    cfg_data             = '0;
    pix_if.valid         = 1'b0;
    pix_if.pixel_in      = '0;
    pix_if.column_offset = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (STIM_TABLE[i]) begin
      if (STIM_TABLE[i].set_cfg) load_config(STIM_TABLE[i].fade, STIM_TABLE[i].bg);
      send_pixel(STIM_TABLE[i].pixel, STIM_TABLE[i].offset,
                 STIM_TABLE[i].known, STIM_TABLE[i].result);
    end

    for (int mode = 0; mode < 3; mode++) begin
      tx_idle_pct = (mode == 0) ? 10 : (mode == 1) ? 68 : 0;
      rx_idle_pct = (mode == 0) ? 68 : (mode == 1) ? 10 : 0;
      for (int p = 0; p < PHASES_PER_MODE; p++) begin
        sel = $urandom_range(3);
        case (p)
          0: fade = 12'd4095;
          1: fade = 12'd1;
          2: fade = '0;
          default: begin
            if (sel == 0) fade = hfb_pkg::FADE_W'($urandom_range(4095, 1));
            else fade = hfb_pkg::FADE_W'($urandom_range(64, 2));
          end
        endcase
        bg = (sel == 1) ? {hfb_pkg::PIX_W{mode[0]}} : hfb_pkg::PIX_W'($urandom);
        load_config(fade, bg);
        for (int k = 0; k < PHASE_ITEMS; k++) begin
          // mostly inside the strip so alpha takes partial values
          if (fade != '0 && $urandom_range(3) != 0)
            off = hfb_pkg::OFF_W'($urandom_range(int'(fade) - 1 + ($urandom_range(1)), 0));
          else
            off = hfb_pkg::OFF_W'($urandom);
          send_pixel(hfb_pkg::PIX_W'($urandom), off, 1'b0, '0);
        end
      end
    end

    pix_if.valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (failed)
      $display("TB_ERROR");
    else
      $display("TB_OK");
    $finish;
  end

endmodule
